// ===== src/spc_pkg.sv =====
// Shared types and constants for the spectral pointwise combiner.
// Used by every module under src; depends on nothing else.
package spc_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned NS_W             = 5;
  localparam int unsigned MODE_W           = 3;
  localparam int unsigned CFG_ADDR_W       = 2;
  localparam int unsigned CFG_DATA_W       = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONV   = 3'd0,
    MODE_DECONV = 3'd1,
    MODE_CORR   = 3'd2,
    MODE_MUL    = 3'd3,
    MODE_ADD    = 3'd4,
    MODE_SUB    = 3'd5
  } mode_e;

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_NORM = CFG_ADDR_W'(1);

  // Per-word control that travels alongside the data through the pipeline.
  typedef struct packed {
    mode_e           mode;
    logic [NS_W-1:0] ns;
    logic            zdiv;
    logic            neg_re;
    logic            neg_im;
    logic            dir_sat;
  } ctrl_t;

endpackage

// ===== src/spc_front.sv =====
// Front end: products, mode-dependent sums, direct results and divider operands.
// Three register stages; depends on spc_pkg.
module spc_front #(
  parameter int unsigned SAMPLE_WIDTH = spc_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = spc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    a_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    a_im_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    b_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    b_im_i,
  input  spc_pkg::mode_e                    mode_i,
  input  logic [spc_pkg::NS_W-1:0]          ns_i,
  output logic                              out_valid_o,
  output spc_pkg::ctrl_t                    ctrl_o,
  output logic [SAMPLE_WIDTH-1:0]           dir_re_o,
  output logic [SAMPLE_WIDTH-1:0]           dir_im_o,
  output logic [2*SAMPLE_WIDTH-1:0]         mag_o,
  output logic [2*SAMPLE_WIDTH-1:0]         nmag_re_o,
  output logic [2*SAMPLE_WIDTH-1:0]         nmag_im_o
);
  import spc_pkg::*;

  localparam int unsigned W   = SAMPLE_WIDTH;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned NW  = 2 * W + 1;
  localparam int unsigned SHW = $clog2(FRAC_BITS + 32);
  localparam logic [SHW-1:0] FRAC_SH = SHW'(FRAC_BITS);

  // Stage 1: products and plain sums.
  logic                 v1_q;
  mode_e                mode1_q;
  logic [NS_W-1:0]      ns1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_q, p_cc_q;
  logic signed [W:0]    as_re_q, as_im_q;
  logic signed [W:0]    as_re_d, as_im_d;

  always_comb begin
    if (mode_i == MODE_SUB) begin
      as_re_d = $signed({a_re_i[W-1], a_re_i}) - $signed({b_re_i[W-1], b_re_i});
      as_im_d = $signed({a_im_i[W-1], a_im_i}) - $signed({b_im_i[W-1], b_im_i});
    end else begin
      as_re_d = $signed({a_re_i[W-1], a_re_i}) + $signed({b_re_i[W-1], b_re_i});
      as_im_d = $signed({a_im_i[W-1], a_im_i}) + $signed({b_im_i[W-1], b_im_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_i;
      ns1_q   <= ns_i;
      p_rr_q  <= a_re_i * b_re_i;
      p_ii_q  <= a_im_i * b_im_i;
      p_ir_q  <= a_im_i * b_re_i;
      p_ri_q  <= a_re_i * b_im_i;
      p_bb_q  <= b_re_i * b_re_i;
      p_cc_q  <= b_im_i * b_im_i;
      as_re_q <= as_re_d;
      as_im_q <= as_im_d;
    end
  end

  // Stage 2: complex combination chosen by mode, and |b|^2.
  logic                 v2_q;
  mode_e                mode2_q;
  logic [NS_W-1:0]      ns2_q;
  logic signed [NW-1:0] n_re_q, n_im_q, n_re_d, n_im_d;
  logic [PW-1:0]        mag2_q;
  logic signed [NW-1:0] rr, ii, ir, ri;

  assign rr = {p_rr_q[PW-1], p_rr_q};
  assign ii = {p_ii_q[PW-1], p_ii_q};
  assign ir = {p_ir_q[PW-1], p_ir_q};
  assign ri = {p_ri_q[PW-1], p_ri_q};

  always_comb begin
    case (mode1_q)
      MODE_CONV, MODE_MUL: begin
        n_re_d = rr - ii;
        n_im_d = ir + ri;
      end
      MODE_DECONV, MODE_CORR: begin
        n_re_d = rr + ii;
        n_im_d = ir - ri;
      end
      MODE_ADD, MODE_SUB: begin
        n_re_d = {{W{as_re_q[W]}}, as_re_q};
        n_im_d = {{W{as_im_q[W]}}, as_im_q};
      end
      default: begin
        n_re_d = '0;
        n_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode2_q <= mode1_q;
      ns2_q   <= ns1_q;
      n_re_q  <= n_re_d;
      n_im_q  <= n_im_d;
      mag2_q  <= $unsigned(p_bb_q) + $unsigned(p_cc_q);
    end
  end

  // Stage 3: scaled and clamped direct result, divider operands.
  logic [SHW-1:0]       sh;
  logic signed [NW-1:0] y_re, y_im, abs_re, abs_im;
  logic                 fit_re, fit_im, dir_valid;
  logic [W-1:0]         cl_re, cl_im;
  logic [W-1:0]         dir_re_q, dir_im_q;
  logic [PW-1:0]        mag_q, nmag_re_q, nmag_im_q;
  logic                 v3_q;
  ctrl_t                ctrl_q, ctrl_d;

  always_comb begin
    case (mode2_q)
      MODE_CONV, MODE_CORR: sh = FRAC_SH + SHW'(ns2_q);
      MODE_MUL:             sh = FRAC_SH;
      default:              sh = '0;
    endcase
  end

  assign y_re   = n_re_q >>> sh;
  assign y_im   = n_im_q >>> sh;
  assign fit_re = (&y_re[NW-1:W-1]) | ~(|y_re[NW-1:W-1]);
  assign fit_im = (&y_im[NW-1:W-1]) | ~(|y_im[NW-1:W-1]);
  assign cl_re  = fit_re ? y_re[W-1:0] :
                  (y_re[NW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  assign cl_im  = fit_im ? y_im[W-1:0] :
                  (y_im[NW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  assign abs_re = n_re_q[NW-1] ? -n_re_q : n_re_q;
  assign abs_im = n_im_q[NW-1] ? -n_im_q : n_im_q;

  // Deconvolve and the two unused codes take no direct result.
  assign dir_valid = (mode2_q == MODE_CONV) || (mode2_q == MODE_CORR) ||
                     (mode2_q == MODE_MUL) || (mode2_q == MODE_ADD) ||
                     (mode2_q == MODE_SUB);

  always_comb begin
    ctrl_d.mode    = mode2_q;
    ctrl_d.ns      = ns2_q;
    ctrl_d.zdiv    = (mode2_q == MODE_DECONV) && (mag2_q == '0);
    ctrl_d.neg_re  = n_re_q[NW-1];
    ctrl_d.neg_im  = n_im_q[NW-1];
    ctrl_d.dir_sat = dir_valid && !(fit_re && fit_im);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q    <= ctrl_d;
      dir_re_q  <= dir_valid ? cl_re : '0;
      dir_im_q  <= dir_valid ? cl_im : '0;
      mag_q     <= mag2_q;
      nmag_re_q <= abs_re[PW-1:0];
      nmag_im_q <= abs_im[PW-1:0];
    end
  end

  assign out_valid_o = v3_q;
  assign ctrl_o      = ctrl_q;
  assign dir_re_o    = dir_re_q;
  assign dir_im_o    = dir_im_q;
  assign mag_o       = mag_q;
  assign nmag_re_o   = nmag_re_q;
  assign nmag_im_o   = nmag_im_q;

endmodule

// ===== src/spc_div.sv =====
// Pipelined restoring divider: two quotients over one shared divisor, one bit per stage.
// Carries an opaque payload alongside; depends on spc_pkg.
module spc_div #(
  parameter int unsigned DW        = 2 * spc_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = spc_pkg::FRAC_BITS_DEF,
  parameter int unsigned PW        = 8,
  localparam int unsigned QW       = DW + FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] num_re_i,
  input  logic [DW-1:0] num_im_i,
  input  logic [PW-1:0] pay_i,
  output logic          out_valid_o,
  output logic [QW-1:0] q_re_o,
  output logic [QW-1:0] q_im_o,
  output logic [PW-1:0] pay_o
);
  import spc_pkg::*;

  logic          v_q      [QW];
  logic [DW-1:0] den_q    [QW];
  logic [DW-1:0] rem_re_q [QW];
  logic [DW-1:0] rem_im_q [QW];
  logic [QW-1:0] nq_re_q  [QW];
  logic [QW-1:0] nq_im_q  [QW];
  logic [PW-1:0] pay_q    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] den_in, rem_re_in, rem_im_in;
    logic [QW-1:0] nq_re_in, nq_im_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   t_re, t_im, d_re, d_im;

    if (k == 0) begin : g_first
      // The numerator enters pre-shifted by the fraction bits; it shifts out
      // at the top while quotient bits shift in at the bottom.
      assign v_in      = in_valid_i;
      assign den_in    = den_i;
      assign rem_re_in = '0;
      assign rem_im_in = '0;
      assign nq_re_in  = QW'(num_re_i) << FRAC_BITS;
      assign nq_im_in  = QW'(num_im_i) << FRAC_BITS;
      assign pay_in    = pay_i;
    end else begin : g_next
      assign v_in      = v_q[k-1];
      assign den_in    = den_q[k-1];
      assign rem_re_in = rem_re_q[k-1];
      assign rem_im_in = rem_im_q[k-1];
      assign nq_re_in  = nq_re_q[k-1];
      assign nq_im_in  = nq_im_q[k-1];
      assign pay_in    = pay_q[k-1];
    end

    assign t_re = {rem_re_in, nq_re_in[QW-1]};
    assign t_im = {rem_im_in, nq_im_in[QW-1]};
    assign d_re = t_re - {1'b0, den_in};
    assign d_im = t_im - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    // A set top bit of the difference means the trial was below the divisor.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]    <= den_in;
        pay_q[k]    <= pay_in;
        rem_re_q[k] <= d_re[DW] ? t_re[DW-1:0] : d_re[DW-1:0];
        rem_im_q[k] <= d_im[DW] ? t_im[DW-1:0] : d_im[DW-1:0];
        nq_re_q[k]  <= {nq_re_in[QW-2:0], ~d_re[DW]};
        nq_im_q[k]  <= {nq_im_in[QW-2:0], ~d_im[DW]};
      end
    end
  end

  assign out_valid_o = v_q[QW-1];
  assign q_re_o      = nq_re_q[QW-1];
  assign q_im_o      = nq_im_q[QW-1];
  assign pay_o       = pay_q[QW-1];

endmodule

// ===== src/spc_back.sv =====
// Back end: sign, normalize and clamp the quotients, then pick the result by mode.
// Two register stages; depends on spc_pkg.
module spc_back #(
  parameter int unsigned SAMPLE_WIDTH = spc_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = spc_pkg::FRAC_BITS_DEF,
  localparam int unsigned QW          = 2 * SAMPLE_WIDTH + FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    in_valid_i,
  input  logic [QW-1:0]           q_re_i,
  input  logic [QW-1:0]           q_im_i,
  input  spc_pkg::ctrl_t          ctrl_i,
  input  logic [SAMPLE_WIDTH-1:0] dir_re_i,
  input  logic [SAMPLE_WIDTH-1:0] dir_im_i,
  output logic                    out_valid_o,
  output logic [SAMPLE_WIDTH-1:0] out_re_o,
  output logic [SAMPLE_WIDTH-1:0] out_im_o,
  output logic                    zero_divisor_o,
  output logic                    saturated_o
);
  import spc_pkg::*;

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned BW = QW + 1;

  // Stage 1: give the quotients the sign of the numerators.
  logic                 v1_q;
  ctrl_t                ctrl1_q;
  logic [W-1:0]         dir_re1_q, dir_im1_q;
  logic signed [BW-1:0] sq_re_q, sq_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl1_q   <= ctrl_i;
      dir_re1_q <= dir_re_i;
      dir_im1_q <= dir_im_i;
      sq_re_q   <= ctrl_i.neg_re ? -$signed({1'b0, q_re_i}) : $signed({1'b0, q_re_i});
      sq_im_q   <= ctrl_i.neg_im ? -$signed({1'b0, q_im_i}) : $signed({1'b0, q_im_i});
    end
  end

  // Stage 2: normalize, clamp and select.
  logic signed [BW-1:0] y_re, y_im;
  logic                 fit_re, fit_im;
  logic [W-1:0]         cl_re, cl_im, re_d, im_d;
  logic                 zd_d, sat_d;
  logic                 v2_q, zd_q, sat_q;
  logic [W-1:0]         re_q, im_q;

  assign y_re   = sq_re_q >>> ctrl1_q.ns;
  assign y_im   = sq_im_q >>> ctrl1_q.ns;
  assign fit_re = (&y_re[BW-1:W-1]) | ~(|y_re[BW-1:W-1]);
  assign fit_im = (&y_im[BW-1:W-1]) | ~(|y_im[BW-1:W-1]);
  assign cl_re  = fit_re ? y_re[W-1:0] :
                  (y_re[BW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
  assign cl_im  = fit_im ? y_im[W-1:0] :
                  (y_im[BW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

  always_comb begin
    if (ctrl1_q.mode != MODE_DECONV) begin
      re_d  = dir_re1_q;
      im_d  = dir_im1_q;
      zd_d  = 1'b0;
      sat_d = ctrl1_q.dir_sat;
    end else if (ctrl1_q.zdiv) begin
      re_d  = '0;
      im_d  = '0;
      zd_d  = 1'b1;
      sat_d = 1'b0;
    end else begin
      re_d  = cl_re;
      im_d  = cl_im;
      zd_d  = 1'b0;
      sat_d = !(fit_re && fit_im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q  <= re_d;
      im_q  <= im_d;
      zd_q  <= zd_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o    = v2_q;
  assign out_re_o       = re_q;
  assign out_im_o       = im_q;
  assign zero_divisor_o = zd_q;
  assign saturated_o    = sat_q;

endmodule

// ===== src/spectral_pointwise_combiner_unit.sv =====
// Spectral pointwise combiner: one complex result per coefficient pair.
// Each word passes through the front end, the one-bit-per-stage divider pipeline and the back end
// to an output register; throughput is one word per cycle while the skid word is empty.
// An output register plus a skid word decouple the output; stalls lose nothing.
// Reset clears mode and norm_shift to zero and empties the pipeline.
// Depends on spc_pkg, spc_front, spc_div and spc_back.
module spectral_pointwise_combiner_unit #(
  parameter int unsigned SAMPLE_WIDTH = spc_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = spc_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W        = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // a_re, a_im, b_re, b_im from the lowest bit up, zero padded
  input  logic [IN_W-1:0]                  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_re, out_im from the lowest bit up, zero padded
  output logic [OUT_W-1:0]                 m_axis_tdata,
  // zero_divisor, saturated from the lowest bit up
  output logic [1:0]                       m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import spc_pkg::*;

  localparam int unsigned W     = SAMPLE_WIDTH;
  localparam int unsigned DW    = 2 * W;
  localparam int unsigned QW    = DW + FRAC_BITS;
  localparam int unsigned PAY_W = $bits(ctrl_t) + 2 * W;
  localparam int unsigned RES_W = 2 * W + 2;

  // Configuration registers.
  mode_e           mode_q;
  logic [NS_W-1:0] ns_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CONV;
      ns_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_MODE: mode_q <= mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_NORM: ns_q   <= cfg_data_i[NS_W-1:0];
        default:  ;
      endcase
    end
  end

  // The whole pipeline advances unless the skid word is occupied.
  logic en;
  logic skid_valid_q, out_valid_q;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  logic          f_valid;
  ctrl_t         f_ctrl;
  logic [W-1:0]  f_dir_re, f_dir_im;
  logic [DW-1:0] f_mag, f_nre, f_nim;

  spc_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s_axis_tvalid),
    .a_re_i     (s_axis_tdata[W-1:0]),
    .a_im_i     (s_axis_tdata[2*W-1:W]),
    .b_re_i     (s_axis_tdata[3*W-1:2*W]),
    .b_im_i     (s_axis_tdata[4*W-1:3*W]),
    .mode_i     (mode_q),
    .ns_i       (ns_q),
    .out_valid_o(f_valid),
    .ctrl_o     (f_ctrl),
    .dir_re_o   (f_dir_re),
    .dir_im_o   (f_dir_im),
    .mag_o      (f_mag),
    .nmag_re_o  (f_nre),
    .nmag_im_o  (f_nim)
  );

  logic             d_valid;
  logic [QW-1:0]    d_qre, d_qim;
  logic [PAY_W-1:0] d_pay;
  ctrl_t            d_ctrl;
  logic [W-1:0]     d_dir_re, d_dir_im;

  spc_div #(
    .DW       (DW),
    .FRAC_BITS(FRAC_BITS),
    .PW       (PAY_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (f_valid),
    .den_i      (f_mag),
    .num_re_i   (f_nre),
    .num_im_i   (f_nim),
    .pay_i      ({f_ctrl, f_dir_im, f_dir_re}),
    .out_valid_o(d_valid),
    .q_re_o     (d_qre),
    .q_im_o     (d_qim),
    .pay_o      (d_pay)
  );

  assign {d_ctrl, d_dir_im, d_dir_re} = d_pay;

  logic         b_valid, b_zd, b_sat;
  logic [W-1:0] b_re, b_im;

  spc_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (d_valid),
    .q_re_i        (d_qre),
    .q_im_i        (d_qim),
    .ctrl_i        (d_ctrl),
    .dir_re_i      (d_dir_re),
    .dir_im_i      (d_dir_im),
    .out_valid_o   (b_valid),
    .out_re_o      (b_re),
    .out_im_o      (b_im),
    .zero_divisor_o(b_zd),
    .saturated_o   (b_sat)
  );

  // Output register and skid word.
  logic [RES_W-1:0] b_res, out_res_q, skid_res_q;
  logic             out_busy;

  assign b_res    = {b_sat, b_zd, b_im, b_re};
  assign out_busy = out_valid_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_busy) begin
      if (en && b_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= en && b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_busy) begin
      if (en && b_valid) begin
        skid_res_q <= b_res;
      end
    end else if (skid_valid_q) begin
      out_res_q <= skid_res_q;
    end else begin
      out_res_q <= b_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_res_q[2*W-1:0]);
  assign m_axis_tuser  = out_res_q[RES_W-1:2*W];

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output register empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid word filled without an output stall");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("zero divisor and saturation flagged together");

endmodule
